// File: rtl/core/cct_pkg.sv
// Shared constants for the color temperature to RGB pipeline.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cct_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int INNER_BITS        = 28;
  localparam int OUT_W             = 22;
  localparam int TEMP_W            = 14;

  localparam logic [TEMP_W-1:0] TEMP_MIN = 14'd1000;
  localparam logic [TEMP_W-1:0] TEMP_MAX = 14'd15000;

  // u = nu/du, v = nv/dv, coefficients scaled to integers
  localparam logic [49:0] K_NU0 = 50'd860117757000000;
  localparam logic [37:0] K_NU1 = 38'd154118254000;
  localparam logic [26:0] K_NU2 = 27'd128641212;
  localparam logic [49:0] K_DU0 = 50'd1000000000000000;
  localparam logic [39:0] K_DU1 = 40'd842420235000;
  localparam logic [29:0] K_DU2 = 30'd708145163;
  localparam logic [54:0] K_NV0 = 55'd31739872600000000;
  localparam logic [41:0] K_NV1 = 42'd4228062450000;
  localparam logic [32:0] K_NV2 = 33'd4204816910;
  localparam logic [56:0] K_DV0 = 57'd100000000000000000;
  localparam logic [41:0] K_DV1 = 42'd2897418160000;
  localparam logic [33:0] K_DV2 = 34'd16145605300;

  // BT.709 matrix scaled by 1e7
  localparam logic signed [25:0] M_RX = 26'sd32404542;
  localparam logic signed [25:0] M_RY = -26'sd15371385;
  localparam logic signed [25:0] M_RZ = -26'sd4985314;
  localparam logic signed [25:0] M_GX = -26'sd9692660;
  localparam logic signed [25:0] M_GY = 26'sd18760108;
  localparam logic signed [25:0] M_GZ = 26'sd415560;
  localparam logic signed [25:0] M_BX = 26'sd556434;
  localparam logic signed [25:0] M_BY = -26'sd2040259;
  localparam logic signed [25:0] M_BZ = 26'sd10572252;

  // matrix scale 1e7 = 2^7 * 5^7; the odd part goes through a reciprocal
  localparam int               SCALE_POW2  = 7;
  localparam logic [16:0]      SCALE_ODD   = 17'd78125;
  localparam logic [38:0]      SCALE_RECIP = 39'd461168601843;  // ceil(2^55 / 5^7)

  localparam logic signed [OUT_W-1:0] OUT_MAX = 22'sd2097151;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -22'sd2097152;

endpackage
`default_nettype wire

// File: rtl/core/cct_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; caller pre-shifts the divisor so the dividend stays below it.
`timescale 1ns / 1ps
`default_nettype none
module cct_div #(
  parameter int W  = 32,
  parameter int QB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [W-1:0]  in_rem,
  input  wire logic [W-1:0]  in_den,
  output logic               out_valid,
  output logic [QB-1:0]      out_quo
);

  // quotient = floor(in_rem * 2^QB / in_den), in_rem < in_den
  logic          valid_r [QB];
  logic [W-1:0]  rem_r [QB-1];
  logic [W-1:0]  den_r [QB-1];
  logic [QB-1:0] quo_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic          prev_valid;
    logic [W-1:0]  prev_rem;
    logic [W-1:0]  prev_den;
    logic [QB-1:0] prev_quo;
    logic [W:0]    dbl;
    logic          ge;
    logic [QB-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev_rem   = in_rem;
      assign prev_den   = in_den;
      assign prev_quo   = '0;
    end else begin : g_next
      assign prev_valid = valid_r[i-1];
      assign prev_rem   = rem_r[i-1];
      assign prev_den   = den_r[i-1];
      assign prev_quo   = quo_r[i-1];
    end

    always_comb begin
      dbl     = {prev_rem, 1'b0};
      ge      = dbl >= {1'b0, prev_den};
      quo_nxt = {prev_quo[QB-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else if (en) begin
        valid_r[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[i] <= quo_nxt;
      end
    end

    // the last stage keeps only the quotient
    if (i < QB - 1) begin : g_carry
      logic [W-1:0] rem_nxt;
      assign rem_nxt = ge ? W'(dbl - {1'b0, prev_den}) : dbl[W-1:0];

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[i] <= rem_nxt;
          den_r[i] <= prev_den;
        end
      end
    end
  end

  assign out_valid = valid_r[QB-1];
  assign out_quo   = quo_r[QB-1];

endmodule
`default_nettype wire

// File: rtl/core/color_temperature_to_rgb.sv
// Color temperature (kelvin) to linear BT.709 RGB in signed fixed point.
// Depends on cct_pkg and cct_div.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                                   | Direction
// input   | in_valid, in_stall, in_temperature_kelvin | in (stall out)
// result  | out_valid, out_stall, out_red/green/blue_level | out (stall in)
//
// One temperature per cycle sustained while no stall holds the pipeline.
// Most of the pipeline depth comes from the two chains of one-bit-per-stage dividers
// (u/v, then X/Z); the matrix scale is a three-stage reciprocal multiply.
// Reset clears all valid bits; data registers are not reset.
// The whole pipeline holds while a result waits under stall; an empty
// output register lets transfers continue.
module color_temperature_to_rgb #(
  parameter int FRACTION_BITS = cct_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [15:0]                      in_temperature_kelvin,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [cct_pkg::OUT_W-1:0]      out_red_level,
  output logic signed [cct_pkg::OUT_W-1:0]      out_green_level,
  output logic signed [cct_pkg::OUT_W-1:0]      out_blue_level
);

  import cct_pkg::*;

  localparam int UV_QB  = INNER_BITS + 1;       // one extra bit for rounding
  localparam int XZ_QB  = INNER_BITS + 3;       // two integer bits
  localparam int CH_QB  = 24;
  localparam int CH_SH  = INNER_BITS - 1 - FRACTION_BITS;
  localparam int W_U    = 58;
  localparam int W_V    = 62;
  localparam int W_XZ   = 32;

  // quotient before rounding is floor(mag / (5^7 * 2^SCALE_SH))
  localparam int          SCALE_SH = CH_SH + SCALE_POW2;
  localparam logic [58:0] A_LIMIT  = 59'(SCALE_ODD) << CH_QB;

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // S1: clamp
  logic              s1_valid_r;
  logic [TEMP_W-1:0] s1_t_r, s1_t_nxt;
  always_comb begin
    if (in_temperature_kelvin < 16'(TEMP_MIN)) begin
      s1_t_nxt = TEMP_MIN;
    end else if (in_temperature_kelvin > 16'(TEMP_MAX)) begin
      s1_t_nxt = TEMP_MAX;
    end else begin
      s1_t_nxt = in_temperature_kelvin[TEMP_W-1:0];
    end
  end

  // S2: square
  logic                s2_valid_r;
  logic [TEMP_W-1:0]   s2_t_r;
  logic [2*TEMP_W-1:0] s2_t2_r;

  // S3: coefficient products
  logic        s3_valid_r;
  logic [51:0] a1_r;
  logic [54:0] a2_r;
  logic [53:0] b1_r;
  logic [57:0] b2_r;
  logic [55:0] c1_r;
  logic [60:0] c2_r;
  logic [55:0] d1_r;
  logic [61:0] d2_r;

  // S4: numerators and denominators
  logic           s4_valid_r;
  logic [W_U-1:0] nu_r, du_r;
  logic [W_V-1:0] nv_r, dv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_t_r  <= s1_t_nxt;
      s2_t_r  <= s1_t_r;
      s2_t2_r <= (2*TEMP_W)'(s1_t_r) * (2*TEMP_W)'(s1_t_r);
      a1_r    <= 52'(K_NU1) * 52'(s2_t_r);
      a2_r    <= 55'(K_NU2) * 55'(s2_t2_r);
      b1_r    <= 54'(K_DU1) * 54'(s2_t_r);
      b2_r    <= 58'(K_DU2) * 58'(s2_t2_r);
      c1_r    <= 56'(K_NV1) * 56'(s2_t_r);
      c2_r    <= 61'(K_NV2) * 61'(s2_t2_r);
      d1_r    <= 56'(K_DV1) * 56'(s2_t_r);
      d2_r    <= 62'(K_DV2) * 62'(s2_t2_r);
      nu_r    <= W_U'(K_NU0) + W_U'(a1_r) + W_U'(a2_r);
      du_r    <= W_U'(K_DU0) + W_U'(b1_r) + W_U'(b2_r);
      nv_r    <= W_V'(K_NV0) + W_V'(c1_r) + W_V'(c2_r);
      dv_r    <= W_V'(K_DV0) - W_V'(d1_r) + W_V'(d2_r);
    end
  end

  // u and v dividers, Q.28 plus a rounding bit
  logic             u_valid, v_valid;
  logic [UV_QB-1:0] u_quo, v_quo;

  cct_div #(.W(W_U), .QB(UV_QB)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s4_valid_r), .in_rem(nu_r), .in_den(du_r),
    .out_valid(u_valid), .out_quo(u_quo)
  );

  cct_div #(.W(W_V), .QB(UV_QB)) v_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s4_valid_r), .in_rem(nv_r), .in_den(dv_r),
    .out_valid(v_valid), .out_quo(v_quo)
  );

  // S5: round u, v; build X and Z operands (Z numerator may be negative)
  logic             s5_valid_r;
  logic [W_XZ-1:0]  xn_r, xzd_r, zn_r;
  logic             zneg_r;
  logic [UV_QB-1:0] uq, vq;
  logic signed [33:0] zs;
  always_comb begin
    uq = UV_QB'((UV_QB + 1)'(u_quo) + 1'b1 >> 1);
    vq = UV_QB'((UV_QB + 1)'(v_quo) + 1'b1 >> 1);
    zs = $signed(34'(4) << INNER_BITS) - $signed(34'(uq)) - $signed(34'(vq) * 34'd10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (en) begin
      s5_valid_r <= u_valid && v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xn_r   <= W_XZ'(uq) * W_XZ'(3);
      xzd_r  <= W_XZ'(vq) << 3;                 // 2v, scaled for two integer bits
      zneg_r <= zs[33];
      zn_r   <= zs[33] ? W_XZ'(-zs) : W_XZ'(zs);
    end
  end

  logic             x_valid, z_valid;
  logic [XZ_QB-1:0] x_quo, z_quo;

  cct_div #(.W(W_XZ), .QB(XZ_QB)) x_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s5_valid_r), .in_rem(xn_r), .in_den(xzd_r),
    .out_valid(x_valid), .out_quo(x_quo)
  );

  cct_div #(.W(W_XZ), .QB(XZ_QB)) z_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s5_valid_r), .in_rem(zn_r), .in_den(xzd_r),
    .out_valid(z_valid), .out_quo(z_quo)
  );

  // Z sign rides alongside the divider
  logic [XZ_QB-1:0] zneg_dly_r;
  always_ff @(posedge clk) begin
    if (en) begin
      zneg_dly_r <= {zneg_dly_r[XZ_QB-2:0], zneg_r};
    end
  end

  // S6: round X, Z
  logic                   s6_valid_r;
  logic signed [W_XZ-1:0] xq_r, zq_r;
  logic [XZ_QB-1:0]       xr, zr;
  always_comb begin
    xr = XZ_QB'((XZ_QB + 1)'(x_quo) + 1'b1 >> 1);
    zr = XZ_QB'((XZ_QB + 1)'(z_quo) + 1'b1 >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r <= 1'b0;
    end else if (en) begin
      s6_valid_r <= x_valid && z_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xq_r <= $signed(W_XZ'(xr));
      zq_r <= zneg_dly_r[XZ_QB-1] ? -$signed(W_XZ'(zr)) : $signed(W_XZ'(zr));
    end
  end

  // S7: matrix products
  logic               s7_valid_r;
  logic signed [57:0] prx_r, prz_r, pgx_r, pgz_r, pbx_r, pbz_r;

  // S8: weighted sums, split into sign and magnitude
  logic        s8_valid_r;
  logic [58:0] rmag_r, gmag_r, bmag_r;
  logic        rneg_r, gneg_r, bneg_r;
  logic signed [59:0] rs, gs, bs;
  always_comb begin
    rs = 60'(prx_r) + 60'(prz_r) + ($signed(60'(M_RY)) <<< INNER_BITS);
    gs = 60'(pgx_r) + 60'(pgz_r) + ($signed(60'(M_GY)) <<< INNER_BITS);
    bs = 60'(pbx_r) + 60'(pbz_r) + ($signed(60'(M_BY)) <<< INNER_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_valid_r <= 1'b0;
      s8_valid_r <= 1'b0;
    end else if (en) begin
      s7_valid_r <= s6_valid_r;
      s8_valid_r <= s7_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prx_r  <= M_RX * xq_r;
      prz_r  <= M_RZ * zq_r;
      pgx_r  <= M_GX * xq_r;
      pgz_r  <= M_GZ * zq_r;
      pbx_r  <= M_BX * xq_r;
      pbz_r  <= M_BZ * zq_r;
      rneg_r <= rs[59];
      gneg_r <= gs[59];
      bneg_r <= bs[59];
      rmag_r <= rs[59] ? 59'(-rs) : 59'(rs);
      gmag_r <= gs[59] ? 59'(-gs) : 59'(gs);
      bmag_r <= bs[59] ? 59'(-bs) : 59'(bs);
    end
  end

  // Scale by 1e7 * 2^(28-F): every power of two is one shift, the odd
  // factor 5^7 is a reciprocal multiply that is exact for quotients below
  // 2^24. S9 forms four partial products, S10 folds the low three, S11 adds
  // the top one. A dividend past that range is flagged and saturates.
  logic [58:0]      chan_mag  [3];
  logic             chan_neg  [3];
  logic [CH_QB-1:0] chan_quo  [3];
  logic [1:0]       chan_flag [3];

  assign chan_mag[0] = rmag_r;
  assign chan_mag[1] = gmag_r;
  assign chan_mag[2] = bmag_r;
  assign chan_neg[0] = rneg_r;
  assign chan_neg[1] = gneg_r;
  assign chan_neg[2] = bneg_r;

  logic s9_valid_r, s10_valid_r, s11_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_valid_r  <= 1'b0;
      s10_valid_r <= 1'b0;
      s11_valid_r <= 1'b0;
    end else if (en) begin
      s9_valid_r  <= s8_valid_r;
      s10_valid_r <= s9_valid_r;
      s11_valid_r <= s10_valid_r;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_scale
    logic [58:0]      a;
    logic             ovf;
    logic [40:0]      hh_r;
    logic [39:0]      hl_r, lh_r;
    logic [38:0]      ll_r;
    logic [40:0]      hh2_r;
    logic [61:0]      low_r;
    logic [CH_QB-1:0] quo_r;
    logic [1:0]       flag1_r, flag2_r, flag3_r;

    always_comb begin
      a   = chan_mag[c] >> SCALE_SH;
      ovf = a >= A_LIMIT;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        hh_r    <= 41'(a[40:20]) * 41'(SCALE_RECIP[38:19]);
        hl_r    <= 40'(a[40:20]) * 40'(SCALE_RECIP[18:0]);
        lh_r    <= 40'(a[19:0]) * 40'(SCALE_RECIP[38:19]);
        ll_r    <= 39'(a[19:0]) * 39'(SCALE_RECIP[18:0]);
        flag1_r <= {chan_neg[c], ovf};
        hh2_r   <= hh_r;
        low_r   <= ((62'({hl_r, 1'b0}) + 62'(lh_r)) << 19) + 62'(ll_r);
        flag2_r <= flag1_r;
        quo_r   <= CH_QB'((42'(hh2_r) + 42'(low_r[61:39])) >> 16);
        flag3_r <= flag2_r;
      end
    end

    assign chan_quo[c]  = quo_r;
    assign chan_flag[c] = flag3_r;
  end

  function automatic logic signed [OUT_W-1:0] finish(
    input logic [CH_QB-1:0] quo,
    input logic [1:0]       flag
  );
    logic [CH_QB-1:0] mag;
    logic             neg;
    logic             ovf;
    mag = CH_QB'((CH_QB + 1)'(quo) + 1'b1 >> 1);
    neg = flag[1];
    ovf = flag[0];
    if (!neg) begin
      if (ovf || mag > CH_QB'(OUT_MAX)) begin
        finish = OUT_MAX;
      end else begin
        finish = OUT_W'(mag);
      end
    end else begin
      if (ovf || mag > CH_QB'(OUT_MAX) + 1'b1) begin
        finish = OUT_MIN;
      end else begin
        finish = OUT_W'(-$signed({1'b0, mag}));
      end
    end
  endfunction

  // output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s11_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= finish(chan_quo[0], chan_flag[0]);
      green_r <= finish(chan_quo[1], chan_flag[1]);
      blue_r  <= finish(chan_quo[2], chan_flag[2]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

endmodule
`default_nettype wire
